@@ rtl/pid_controller_with_clamps_assert.svh @@
// ---------------------------------------------------------------------------
// PID controller assertion macros
// Concurrent assertion helpers that fall away to nothing under synthesis.
// ---------------------------------------------------------------------------
`ifndef PID_CONTROLLER_WITH_CLAMPS_ASSERT_SVH
`define PID_CONTROLLER_WITH_CLAMPS_ASSERT_SVH
`ifndef SYNTHESIS
`define PIDC_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("PID controller assertion failed");
`define PIDC_ASSERT(label, prop) `PIDC_ASSERT_CLK(label, aclk, aresetn, prop)
`else
`define PIDC_ASSERT_CLK(label, clk, rst_n, prop)
`define PIDC_ASSERT(label, prop)
`endif
`endif

@@ rtl/pidc_pkg.sv @@
// ---------------------------------------------------------------------------
// PID controller package
// Widths, register indexes and reset values of the clamped PID controller.
// ---------------------------------------------------------------------------
package pidc_pkg;

    localparam int DATA_W  = 32;
    localparam int LIM_W   = 31;
    localparam int IDX_W   = 3;
    localparam int OP_W    = 33;
    localparam int PROD_W  = 2 * OP_W;
    localparam int FRAC_W  = 16;
    localparam int TERM_W  = PROD_W - FRAC_W;
    localparam int ACC_W   = TERM_W + 2;

    typedef logic signed [DATA_W-1:0] q16_t;
    typedef logic        [LIM_W-1:0]  lim_t;
    typedef logic        [IDX_W-1:0]  reg_idx_t;

    localparam reg_idx_t REG_KP          = 3'd0;
    localparam reg_idx_t REG_KI          = 3'd1;
    localparam reg_idx_t REG_KD          = 3'd2;
    localparam reg_idx_t REG_INT_LIMIT   = 3'd3;
    localparam reg_idx_t REG_OUT_LIMIT   = 3'd4;
    localparam reg_idx_t REG_DERIV_RATE  = 3'd5;

    localparam q16_t KP_RESET          = 32'sd32768;
    localparam q16_t KI_RESET          = 32'sd6554;
    localparam q16_t KD_RESET          = 32'sd0;
    localparam lim_t INT_LIMIT_RESET   = 31'd3277;
    localparam lim_t OUT_LIMIT_RESET   = 31'd9830;
    localparam lim_t DERIV_RATE_RESET  = 31'd655360;

endpackage

@@ rtl/pid_controller_with_clamps.sv @@
// ---------------------------------------------------------------------------
// Clamped PID controller
// Q16.16 PID step with anti-windup integral clamp and drive clamp, built
// around one shared 33 x 33 bit signed multiplier.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Transfer when              Contents
//  s_*       in         s_tvalid && s_tready       error sample, restart flag
//  m_*       out        m_tvalid && m_tready       drive, clamp flag
//  cfg_*     in         cfg_valid && cfg_ready     register index and value
//
// An accepted sample occupies the sequencer, which takes no new sample until idle, for
// one multiplier pass each for the derivative, kp, kd and ki products, an accumulate
// step and a clamp step that loads the output register.
// The sequencer only holds at the clamp step while an earlier result is still waiting.
// Reset is synchronous and active low, and restores the gains, limits and state.
// Configuration writes are always taken.

`include "pid_controller_with_clamps_assert.svh"

module pid_controller_with_clamps (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] error_sample
    input  logic        s_tuser,   // [0] restart
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] drive
    output logic        m_tuser,   // [0] drive_clamped
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DER  = 3'd1;
    localparam logic [2:0] S_KP   = 3'd2;
    localparam logic [2:0] S_KD   = 3'd3;
    localparam logic [2:0] S_KI   = 3'd4;
    localparam logic [2:0] S_ACC  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    localparam int OP_W   = pidc_pkg::OP_W;
    localparam int PROD_W = pidc_pkg::PROD_W;
    localparam int TERM_W = pidc_pkg::TERM_W;
    localparam int ACC_W  = pidc_pkg::ACC_W;
    localparam int DW     = pidc_pkg::DATA_W;
    localparam int LW     = pidc_pkg::LIM_W;

    // Configuration registers.
    pidc_pkg::q16_t kp_reg, ki_reg, kd_reg;
    pidc_pkg::lim_t int_limit_reg, out_limit_reg, deriv_rate_reg;

    // Controller state and working registers.
    logic [2:0]                 state_reg;
    pidc_pkg::q16_t             err_reg;
    pidc_pkg::q16_t             integral_reg;
    pidc_pkg::q16_t             prev_err_reg;
    logic                       has_prev_reg;
    pidc_pkg::q16_t             deriv_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       m_valid_reg;
    pidc_pkg::q16_t             drive_reg;
    logic                       clamped_reg;

    logic                       s_accept;
    logic                       out_free;
    logic signed [OP_W-1:0]     mul_a, mul_b;
    logic signed [TERM_W-1:0]   term;
    logic signed [ACC_W-1:0]    term_ext;
    pidc_pkg::q16_t             deriv_sat;
    logic signed [OP_W-1:0]     int_sum, int_lim_ext;
    pidc_pkg::q16_t             integral_next;
    logic signed [ACC_W-1:0]    out_lim_ext;
    pidc_pkg::q16_t             drive_next;
    logic                       clamped_next;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = drive_reg;
    assign m_tuser   = clamped_reg;

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_DER: begin
                if (has_prev_reg) begin
                    mul_a = {err_reg[DW-1], err_reg} - {prev_err_reg[DW-1], prev_err_reg};
                end
                mul_b = {2'b00, deriv_rate_reg};
            end
            S_KP: begin
                mul_a = {kp_reg[DW-1], kp_reg};
                mul_b = {err_reg[DW-1], err_reg};
            end
            S_KD: begin
                mul_a = {kd_reg[DW-1], kd_reg};
                mul_b = {deriv_reg[DW-1], deriv_reg};
            end
            S_KI: begin
                mul_a = {ki_reg[DW-1], ki_reg};
                mul_b = {integral_reg[DW-1], integral_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Dropping the sixteen fraction bits of a signed product is a floor.
    always_comb begin
        term     = prod_reg[PROD_W-1:pidc_pkg::FRAC_W];
        term_ext = {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
        if (term[TERM_W-1:DW-1] != {(TERM_W-DW+1){term[TERM_W-1]}}) begin
            deriv_sat = term[TERM_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            deriv_sat = term[DW-1:0];
        end
    end

    // Anti-windup integral update.
    always_comb begin
        int_sum     = {integral_reg[DW-1], integral_reg} + {err_reg[DW-1], err_reg};
        int_lim_ext = {2'b00, int_limit_reg};
        if (int_sum > int_lim_ext) begin
            integral_next = int_lim_ext[DW-1:0];
        end else if (int_sum < -int_lim_ext) begin
            integral_next = -int_lim_ext[DW-1:0];
        end else begin
            integral_next = int_sum[DW-1:0];
        end
    end

    // Drive clamp on the full-width sum.
    always_comb begin
        out_lim_ext = {{(ACC_W-LW){1'b0}}, out_limit_reg};
        clamped_next = 1'b1;
        if (acc_reg > out_lim_ext) begin
            drive_next = out_lim_ext[DW-1:0];
        end else if (acc_reg < -out_lim_ext) begin
            drive_next = -out_lim_ext[DW-1:0];
        end else begin
            drive_next   = acc_reg[DW-1:0];
            clamped_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg         <= pidc_pkg::KP_RESET;
            ki_reg         <= pidc_pkg::KI_RESET;
            kd_reg         <= pidc_pkg::KD_RESET;
            int_limit_reg  <= pidc_pkg::INT_LIMIT_RESET;
            out_limit_reg  <= pidc_pkg::OUT_LIMIT_RESET;
            deriv_rate_reg <= pidc_pkg::DERIV_RATE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                pidc_pkg::REG_KP:         kp_reg         <= cfg_data;
                pidc_pkg::REG_KI:         ki_reg         <= cfg_data;
                pidc_pkg::REG_KD:         kd_reg         <= cfg_data;
                pidc_pkg::REG_INT_LIMIT:  int_limit_reg  <= cfg_data[LW-1:0];
                pidc_pkg::REG_OUT_LIMIT:  out_limit_reg  <= cfg_data[LW-1:0];
                pidc_pkg::REG_DERIV_RATE: deriv_rate_reg <= cfg_data[LW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            integral_reg <= '0;
            prev_err_reg <= '0;
            has_prev_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            // A new result is loaded from the clamp step, else a taken one is cleared.
            if (state_reg == S_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        err_reg <= s_tdata;
                        if (s_tuser) begin
                            integral_reg <= '0;
                            prev_err_reg <= '0;
                            has_prev_reg <= 1'b0;
                        end
                        state_reg <= S_DER;
                    end
                end
                S_DER: begin
                    prod_reg     <= mul_a * mul_b;
                    integral_reg <= integral_next;
                    prev_err_reg <= err_reg;
                    has_prev_reg <= 1'b1;
                    state_reg    <= S_KP;
                end
                S_KP: begin
                    deriv_reg <= deriv_sat;
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_KD;
                end
                S_KD: begin
                    acc_reg   <= term_ext;
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_KI;
                end
                S_KI: begin
                    acc_reg   <= acc_reg + term_ext;
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    acc_reg   <= acc_reg + term_ext;
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        drive_reg   <= drive_next;
                        clamped_reg <= clamped_next;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // A transfer in always starts the derivative pass.
    `PIDC_ASSERT(a_accept_starts, s_accept |=> (state_reg == S_DER))
    // A new result only appears from the clamp step.
    `PIDC_ASSERT(a_result_from_fin, $rose(m_valid_reg) |-> ($past(state_reg) == S_FIN))
    // History is marked valid once the derivative pass has run.
    `PIDC_ASSERT(a_history_set, (state_reg == S_DER) |=> has_prev_reg)
    // The clamp step never overwrites a result that is still waiting.
    `PIDC_ASSERT(a_no_overwrite, (m_valid_reg && !m_tready) |=> $stable(drive_reg))

endmodule
